### src/irm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irm_pkg: shared codes for the interval range map
// Item action codes and result status codes.
// ----------------------------------------------------------------------------
package irm_pkg;

	localparam logic ACT_ASSIGN = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

endpackage

### src/irm_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irm_mem: breakpoint storage
// Key and value arrays, one write and one registered read per cycle. Entry 0
// reads as (0, default) until it is written after reset or a table clear.
// ----------------------------------------------------------------------------
module irm_mem #(
	parameter int DEPTH = 64,
	parameter int KW    = 32,
	parameter int VW    = 8,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear,
	input  logic [VW-1:0] default_val,
	input  logic          we,
	input  logic [AW-1:0] wr_addr,
	input  logic [KW-1:0] wr_key,
	input  logic [VW-1:0] wr_val,
	input  logic [AW-1:0] rd_addr,
	output logic [KW-1:0] rd_key,
	output logic [VW-1:0] rd_val
);

	logic [KW-1:0] keys_mem [DEPTH];
	logic [VW-1:0] vals_mem [DEPTH];
	logic [KW-1:0] rd_key_q;
	logic [VW-1:0] rd_val_q;
	logic          rd_a0_q;
	logic          e0_ok_q;

	always_ff @(posedge clk) begin
		if (we) begin
			keys_mem[wr_addr] <= wr_key;
			vals_mem[wr_addr] <= wr_val;
		end
		rd_key_q <= keys_mem[rd_addr];
		rd_val_q <= vals_mem[rd_addr];
		rd_a0_q  <= (rd_addr == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e0_ok_q <= 1'b0;
		end else if (clear) begin
			e0_ok_q <= 1'b0;
		end else if (we && wr_addr == '0) begin
			e0_ok_q <= 1'b1;
		end
	end

	assign rd_key = (rd_a0_q && !e0_ok_q) ? '0 : rd_key_q;
	assign rd_val = (rd_a0_q && !e0_ok_q) ? default_val : rd_val_q;

	property p_no_write_on_clear;
		@(posedge clk) disable iff (!arst_n) clear |-> !we;
	endproperty
	a_no_write_on_clear: assert property (p_no_write_on_clear)
		else $error("table write during clear");

	property p_e0_cleared;
		@(posedge clk) disable iff (!arst_n) clear |=> !e0_ok_q;
	endproperty
	a_e0_cleared: assert property (p_e0_cleared)
		else $error("entry 0 override not restored after clear");

	property p_e0_set;
		@(posedge clk) disable iff (!arst_n) (we && wr_addr == '0 && !clear) |=> e0_ok_q;
	endproperty
	a_e0_set: assert property (p_e0_set)
		else $error("entry 0 write not recorded");

endmodule

### src/irm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irm_ctrl: scan and rewrite sequencer
// Scans the stored breakpoints once per item, then for an accepted assign shifts
// the tail entries and writes the start breakpoint and, unless one already sits at the end key, the end breakpoint.
// ----------------------------------------------------------------------------
module irm_ctrl #(
	parameter int DEPTH = 64,
	parameter int KW    = 32,
	parameter int VW    = 8,
	parameter int AW    = 6,
	parameter int CW    = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear,
	input  logic          in_fire,
	input  logic          action,
	input  logic [KW-1:0] start_key,
	input  logic [KW-1:0] end_key,
	input  logic [VW-1:0] assign_value,
	output logic          idle,
	input  logic          slot_free,
	output logic          res_fire,
	output logic [VW-1:0] res_found,
	output logic [1:0]    res_status,
	output logic [CW-1:0] res_count,
	output logic          we,
	output logic [AW-1:0] wr_addr,
	output logic [KW-1:0] wr_key,
	output logic [VW-1:0] wr_val,
	output logic [AW-1:0] rd_addr,
	input  logic [KW-1:0] rd_key,
	input  logic [VW-1:0] rd_val
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_DECIDE  = 3'd2;
	localparam logic [2:0] S_MOVE_RD = 3'd3;
	localparam logic [2:0] S_MOVE_WR = 3'd4;
	localparam logic [2:0] S_WRITE_S = 3'd5;
	localparam logic [2:0] S_WRITE_E = 3'd6;
	localparam logic [2:0] S_RESULT  = 3'd7;

	logic [2:0]    state_q;
	logic          act_q;
	logic [KW-1:0] s_q, e_q;
	logic [VW-1:0] v_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rd_i_q;
	logic          pend_s1;
	logic [CW-1:0] below_q, aoa_q, rem_q;
	logic          endp_q;
	logic [VW-1:0] fv_q, eold_q;
	logic [CW:0]   need_q;
	logic [1:0]    stat_q;
	logic [AW-1:0] mv_src_q, mv_dst_q;
	logic          down_q;

	logic          issue;
	logic [CW:0]   need;
	logic [CW:0]   dst;
	logic [CW:0]   src;

	assign issue = (state_q == S_SCAN) && (rd_i_q < cnt_q);
	assign need  = {1'b0, below_q} + {1'b0, aoa_q} + (CW+1)'(1) + (CW+1)'(!endp_q);
	assign dst   = {1'b0, below_q} + (CW+1)'(1) + (CW+1)'(!endp_q);
	assign src   = {1'b0, cnt_q} - {1'b0, aoa_q};

	always_comb begin
		rd_addr = (state_q == S_MOVE_RD) ? mv_src_q : rd_i_q[AW-1:0];
		we      = 1'b0;
		wr_addr = mv_dst_q;
		wr_key  = rd_key;
		wr_val  = rd_val;
		unique case (state_q)
			S_MOVE_WR: we = 1'b1;
			S_WRITE_S: begin
				we      = 1'b1;
				wr_addr = below_q[AW-1:0];
				wr_key  = s_q;
				wr_val  = v_q;
			end
			S_WRITE_E: begin
				we      = 1'b1;
				wr_addr = AW'(below_q + CW'(1));
				wr_key  = e_q;
				wr_val  = eold_q;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_q <= action;
			s_q   <= start_key;
			e_q   <= end_key;
			v_q   <= assign_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= CW'(1);
			rd_i_q   <= '0;
			pend_s1  <= 1'b0;
			below_q  <= '0;
			aoa_q    <= '0;
			rem_q    <= '0;
			endp_q   <= 1'b0;
			fv_q     <= '0;
			eold_q   <= '0;
			need_q   <= '0;
			stat_q   <= irm_pkg::STAT_DONE;
			mv_src_q <= '0;
			mv_dst_q <= '0;
			down_q   <= 1'b0;
		end else begin
			if (clear) begin
				cnt_q <= CW'(1);
			end
			pend_s1 <= issue;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_SCAN;
						rd_i_q  <= '0;
						below_q <= '0;
						aoa_q   <= '0;
						endp_q  <= 1'b0;
					end
				end
				S_SCAN: begin
					if (issue) begin
						rd_i_q <= rd_i_q + CW'(1);
					end
					if (pend_s1) begin
						if (rd_key <= s_q) fv_q <= rd_val;
						if (rd_key < s_q) below_q <= below_q + CW'(1);
						if (rd_key >= e_q) aoa_q <= aoa_q + CW'(1);
						if (rd_key == e_q) endp_q <= 1'b1;
						if (rd_key <= e_q) eold_q <= rd_val;
					end else if (!issue) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					need_q <= need;
					rem_q  <= aoa_q;
					if (act_q == irm_pkg::ACT_LOOKUP) begin
						stat_q  <= irm_pkg::STAT_DONE;
						state_q <= S_RESULT;
					end else if (!(s_q < e_q)) begin
						stat_q  <= irm_pkg::STAT_EMPTY;
						state_q <= S_RESULT;
					end else if (need > (CW+1)'(DEPTH)) begin
						stat_q  <= irm_pkg::STAT_FULL;
						state_q <= S_RESULT;
					end else begin
						stat_q <= irm_pkg::STAT_DONE;
						// tail moves up: copy from the top so nothing is overwritten early
						down_q <= (dst > src);
						if (dst > src) begin
							mv_src_q <= AW'(cnt_q - CW'(1));
							mv_dst_q <= AW'(need - (CW+1)'(1));
						end else begin
							mv_src_q <= AW'(src);
							mv_dst_q <= AW'(dst);
						end
						state_q <= (aoa_q == '0 || dst == src) ? S_WRITE_S : S_MOVE_RD;
					end
				end
				S_MOVE_RD: state_q <= S_MOVE_WR;
				S_MOVE_WR: begin
					rem_q <= rem_q - CW'(1);
					if (down_q) begin
						mv_src_q <= mv_src_q - AW'(1);
						mv_dst_q <= mv_dst_q - AW'(1);
					end else begin
						mv_src_q <= mv_src_q + AW'(1);
						mv_dst_q <= mv_dst_q + AW'(1);
					end
					state_q <= (rem_q == CW'(1)) ? S_WRITE_S : S_MOVE_RD;
				end
				S_WRITE_S: begin
					cnt_q   <= CW'(need_q);
					state_q <= endp_q ? S_RESULT : S_WRITE_E;
				end
				S_WRITE_E: state_q <= S_RESULT;
				S_RESULT: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle       = (state_q == S_IDLE);
	assign res_fire   = (state_q == S_RESULT) && slot_free;
	assign res_found  = (act_q == irm_pkg::ACT_LOOKUP) ? fv_q : '0;
	assign res_status = stat_q;
	assign res_count  = cnt_q;

	property p_cnt_range;
		@(posedge clk) disable iff (!arst_n) (cnt_q != '0) && (cnt_q <= CW'(DEPTH));
	endproperty
	a_cnt_range: assert property (p_cnt_range)
		else $error("entry count out of range");

	property p_reject_keeps_cnt;
		@(posedge clk) disable iff (!arst_n)
			(state_q == S_DECIDE && state_q != $past(state_q)) |-> $stable(cnt_q);
	endproperty
	a_reject_keeps_cnt: assert property (p_reject_keeps_cnt)
		else $error("entry count changed during scan");

	property p_fire_to_idle;
		@(posedge clk) disable iff (!arst_n) res_fire |=> (state_q == S_IDLE);
	endproperty
	a_fire_to_idle: assert property (p_fire_to_idle)
		else $error("sequencer did not return to idle after result");

endmodule

### src/interval_range_map.sv
`timescale 1ns / 1ps
// A lookup scans every entry in use before its result is ready.
// An assign also moves any tail entries that must shift, then writes one or two breakpoints.
// Throughput: one item at a time; the scan reads one table entry per cycle
// from the single read port of the breakpoint memory.
// Reset: table holds one entry (0, default_value); default_value resets to 0.
// A write of default_value clears the table the same way.
// ----------------------------------------------------------------------------
// interval_range_map: sorted breakpoint table of key ranges
// Assigns values over key ranges and looks up the value in force at a key.
// ----------------------------------------------------------------------------
module interval_range_map #(
	parameter int TABLE_DEPTH = 64,
	parameter int KEY_BITS    = 32,
	parameter int VALUE_BITS  = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [VALUE_BITS-1:0]              cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               action,
	input  logic [KEY_BITS-1:0]                start_key,
	input  logic [KEY_BITS-1:0]                end_key,
	input  logic [VALUE_BITS-1:0]              assign_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [VALUE_BITS-1:0]              found_value,
	output logic [1:0]                         status,
	output logic [$clog2(TABLE_DEPTH+1)-1:0]   entries_in_use
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH+1);

	logic [VALUE_BITS-1:0] default_q;
	logic                  idle, slot_free, res_fire, in_fire;
	logic [VALUE_BITS-1:0] res_found;
	logic [1:0]            res_status;
	logic [CW-1:0]         res_count;
	logic                  we;
	logic [AW-1:0]         wr_addr, rd_addr;
	logic [KEY_BITS-1:0]   wr_key, rd_key;
	logic [VALUE_BITS-1:0] wr_val, rd_val;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] found_q;
	logic [1:0]            status_q;
	logic [CW-1:0]         count_q;

	assign in_ready  = idle;
	assign in_fire   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_q <= '0;
		end else if (cfg_we) begin
			default_q <= cfg_wdata;
		end
	end

	irm_mem #(
		.DEPTH(TABLE_DEPTH), .KW(KEY_BITS), .VW(VALUE_BITS), .AW(AW)
	) u_mem (
		.clk(clk), .arst_n(arst_n), .clear(cfg_we), .default_val(default_q),
		.we(we), .wr_addr(wr_addr), .wr_key(wr_key), .wr_val(wr_val),
		.rd_addr(rd_addr), .rd_key(rd_key), .rd_val(rd_val)
	);

	irm_ctrl #(
		.DEPTH(TABLE_DEPTH), .KW(KEY_BITS), .VW(VALUE_BITS), .AW(AW), .CW(CW)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n), .clear(cfg_we), .in_fire(in_fire),
		.action(action), .start_key(start_key), .end_key(end_key),
		.assign_value(assign_value), .idle(idle), .slot_free(slot_free),
		.res_fire(res_fire), .res_found(res_found), .res_status(res_status),
		.res_count(res_count), .we(we), .wr_addr(wr_addr), .wr_key(wr_key),
		.wr_val(wr_val), .rd_addr(rd_addr), .rd_key(rd_key), .rd_val(rd_val)
	);

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			found_q  <= res_found;
			status_q <= res_status;
			count_q  <= res_count;
		end
	end

	assign out_valid      = out_valid_q;
	assign found_value    = found_q;
	assign status         = status_q;
	assign entries_in_use = count_q;

	property p_no_overwrite;
		@(posedge clk) disable iff (!arst_n) (out_valid_q && !out_ready) |-> !res_fire;
	endproperty
	a_no_overwrite: assert property (p_no_overwrite)
		else $error("result overwrote a pending beat");

	property p_busy_blocks_input;
		@(posedge clk) disable iff (!arst_n) res_fire |-> !in_ready;
	endproperty
	a_busy_blocks_input: assert property (p_busy_blocks_input)
		else $error("input taken while result pending in sequencer");

	property p_status_code;
		@(posedge clk) disable iff (!arst_n) out_valid_q |-> (status_q <= irm_pkg::STAT_FULL);
	endproperty
	a_status_code: assert property (p_status_code)
		else $error("bad status code");

endmodule

### tb/interval_range_map_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_range_map_test: self-checking bench for the interval range map
// Drives assign and lookup beats, predicts each result from a local copy of
// the breakpoint table, and compares every result beat field by field.
// ----------------------------------------------------------------------------
module interval_range_map_test;

	localparam int DEPTH = 64;
	localparam int LIMIT = 20000;

	typedef struct packed {
		logic [7:0] found;
		logic [1:0] stat;
		logic [6:0] used;
	} map_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic        action;
	logic [31:0] start_key;
	logic [31:0] end_key;
	logic [7:0]  assign_value;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  found_value;
	logic [1:0]  status;
	logic [6:0]  entries_in_use;

	interval_range_map dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.start_key(start_key), .end_key(end_key), .assign_value(assign_value),
		.out_valid(out_valid), .out_ready(out_ready), .found_value(found_value),
		.status(status), .entries_in_use(entries_in_use)
	);

	// predicted table
	logic [31:0] bp_key [DEPTH];
	logic [7:0]  bp_val [DEPTH];
	int          bp_count;

	map_result_t pending_results[$];
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          recv_hold;
	bit          failed;
	int          quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] value_at(logic [31:0] k);
		logic [7:0] r;
		r = bp_val[0];
		for (int i = 0; i < bp_count; i++)
			if (bp_key[i] <= k)
				r = bp_val[i];
		return r;
	endfunction

	function automatic logic [1:0] apply_assign(logic [31:0] s, logic [31:0] e,
			logic [7:0] v);
		int below, above, n;
		bit at_end;
		logic [7:0] end_old;
		logic [31:0] nk [DEPTH];
		logic [7:0]  nv [DEPTH];
		below = 0; above = 0; n = 0; at_end = 0;
		if (!(s < e))
			return irm_pkg::STAT_EMPTY;
		end_old = value_at(e);
		for (int i = 0; i < bp_count; i++) begin
			if (bp_key[i] < s) below++;
			if (bp_key[i] >= e) above++;
			if (bp_key[i] == e) at_end = 1;
		end
		if (below + 1 + (at_end ? 0 : 1) + above > DEPTH)
			return irm_pkg::STAT_FULL;
		for (int i = 0; i < bp_count; i++)
			if (bp_key[i] < s) begin
				nk[n] = bp_key[i]; nv[n] = bp_val[i]; n++;
			end
		nk[n] = s; nv[n] = v; n++;
		if (!at_end) begin
			nk[n] = e; nv[n] = end_old; n++;
		end
		for (int i = 0; i < bp_count; i++)
			if (bp_key[i] >= e) begin
				nk[n] = bp_key[i]; nv[n] = bp_val[i]; n++;
			end
		for (int i = 0; i < n; i++) begin
			bp_key[i] = nk[i]; bp_val[i] = nv[i];
		end
		bp_count = n;
		return irm_pkg::STAT_DONE;
	endfunction

	function automatic map_result_t predict_item(logic act, logic [31:0] s,
			logic [31:0] e, logic [7:0] v);
		map_result_t r;
		r.found = 8'd0;
		r.stat = irm_pkg::STAT_DONE;
		if (act == irm_pkg::ACT_LOOKUP)
			r.found = value_at(s);
		else
			r.stat = apply_assign(s, e, v);
		r.used = bp_count[6:0];
		return r;
	endfunction

	task automatic send_item(logic act, logic [31:0] s, logic [31:0] e, logic [7:0] v);
		while ($urandom_range(99) < send_idle_pct)
			@(posedge clk);
		pending_results.push_back(predict_item(act, s, e, v));
		in_valid <= 1'b1;
		action <= act;
		start_key <= s;
		end_key <= e;
		assign_value <= v;
		do @(posedge clk); while (!in_ready);
		in_valid <= 1'b0;
		// block is busy after accepting a beat; step past this edge
		@(posedge clk);
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2 * DEPTH + 20) @(posedge clk);
	endtask

	task automatic write_default(logic [7:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		bp_key[0] = 32'd0;
		bp_val[0] = v;
		bp_count = 1;
	endtask

	// keys mostly from a small pool so ranges collide often
	function automatic logic [31:0] pick_key();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(200);
		endcase
	endfunction

	task automatic random_item();
		logic [31:0] a, b;
		a = pick_key();
		b = pick_key();
		if ($urandom_range(9) < 7 && a > b) begin
			a = a ^ b; b = a ^ b; a = a ^ b;
		end
		send_item($urandom_range(1) ? irm_pkg::ACT_LOOKUP : irm_pkg::ACT_ASSIGN, a, b,
			8'($urandom));
	endtask

	task automatic test_directed();
		write_default(8'hFF);
		send_item(irm_pkg::ACT_LOOKUP, 32'd0, 32'd0, 8'd0);
		send_item(irm_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		send_item(irm_pkg::ACT_ASSIGN, 32'd10, 32'd10, 8'h11);       // empty range
		send_item(irm_pkg::ACT_ASSIGN, 32'd20, 32'd5, 8'h11);        // reversed range
		send_item(irm_pkg::ACT_ASSIGN, 32'd0, 32'd100, 8'h00);       // at key zero
		send_item(irm_pkg::ACT_ASSIGN, 32'd50, 32'hFFFF_FFFF, 8'hA5);
		send_item(irm_pkg::ACT_ASSIGN, 32'd40, 32'd60, 8'h5A);       // end inside run
		send_item(irm_pkg::ACT_ASSIGN, 32'd30, 32'd50, 8'h3C);       // end inside run
		send_item(irm_pkg::ACT_ASSIGN, 32'd0, 32'hFFFF_FFFF, 8'h77); // covers all but the top key
		send_item(irm_pkg::ACT_LOOKUP, 32'd45, 32'd0, 8'd0);
		send_item(irm_pkg::ACT_LOOKUP, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 8'd0);
		send_item(irm_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'd0, 8'd0);
		// fill the table until assigns are rejected
		for (int i = 0; i < 36; i++)
			send_item(irm_pkg::ACT_ASSIGN, 32'd1000 + 4 * i, 32'd1002 + 4 * i, 8'(i));
		send_item(irm_pkg::ACT_LOOKUP, 32'd1005, 32'hFFFF_FFFF, 8'd0);
		write_default(8'h00);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(39) == 0)
				write_default($urandom_range(3) == 0 ? 8'hFF : 8'($urandom));
			random_item();
		end
	endtask

	task automatic test_backpressure();
		recv_hold = 1'b1;
		for (int i = 0; i < 12; i++)
			random_item();
		recv_hold = 1'b0;
		// sender waits for every result
		while (pending_results.size() != 0)
			@(posedge clk);
		random_item();
	endtask

	// receiver: random ready, with a long hold-off when asked
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (recv_hold) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				recv_hold = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		map_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				if (found_value !== want.found) begin
					$error("found_value expected %0h got %0h", want.found, found_value);
					failed = 1'b1;
				end
				if (status !== want.stat) begin
					$error("status expected %0d got %0d", want.stat, status);
					failed = 1'b1;
				end
				if (entries_in_use !== want.used) begin
					$error("entries_in_use expected %0d got %0d", want.used, entries_in_use);
					failed = 1'b1;
				end
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || pending_results.size() == 0)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		failed = 1'b0;
		quiet_cycles = 0;
		recv_hold = 1'b0;
		send_idle_pct = 25;
		recv_idle_pct = 56;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		in_valid = 1'b0;
		action = irm_pkg::ACT_ASSIGN;
		start_key = 32'd0;
		end_key = 32'd0;
		assign_value = 8'd0;
		bp_key[0] = 32'd0;
		bp_val[0] = 8'd0;
		bp_count = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_item(irm_pkg::ACT_LOOKUP, 32'd7, 32'd0, 8'd0);  // reset table
		test_directed();
		test_random(280);
		send_idle_pct = 56;
		recv_idle_pct = 25;
		test_random(280);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random(260);
		drain_results();
		if (!failed)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
